// ===== src/twps_pkg.sv =====
// Shared widths, shading constants and the item kind code for the textured wall pixel shader.
// No dependencies; the top level takes names from here by scope.
package twps_pkg;

  localparam int CHAN_W   = 8;
  localparam int COLOR_W  = 24;
  localparam int LH_W     = 16;
  localparam int DIST_W   = 16;

  // |row - SCREEN_HEIGHT/2 + slice height/2| stays below 2**16 for every legal screen height
  localparam int NMAG_W   = 16;

  localparam int SHADE_NUM_W = 12;
  localparam int SHADE_DEN_W = 17;
  localparam int PROD_W      = CHAN_W + SHADE_NUM_W;
  localparam int CLAMP_W     = DIST_W + 2;

  // factor = 2560 / (2560 + distance); on side 1 the 7/10 folds into 1792 / (2560 + distance)
  localparam logic [SHADE_NUM_W-1:0] SHADE_BASE_NUM = 12'd2560;
  localparam logic [SHADE_NUM_W-1:0] SHADE_DARK_NUM = 12'd1792;
  localparam logic [SHADE_DEN_W-1:0] SHADE_BASE_DEN = 17'd2560;
  // below the 0.3 floor: 3/10, or 21/100 on side 1
  localparam logic [SHADE_NUM_W-1:0] CLAMP_NUM      = 12'd3;
  localparam logic [SHADE_DEN_W-1:0] CLAMP_DEN      = 17'd10;
  localparam logic [SHADE_NUM_W-1:0] CLAMP_DARK_NUM = 12'd21;
  localparam logic [SHADE_DEN_W-1:0] CLAMP_DARK_DEN = 17'd100;
  // factor < 0.3 exactly when 3 * distance > 17920
  localparam logic [CLAMP_W-1:0]     CLAMP_LIMIT    = 18'd17920;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_SHADE = 1'b1
  } item_kind_t;

endpackage

// ===== src/twps_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Used by the textured wall pixel shader for the texel row and the shading scale.
module twps_div #(
  parameter int DEN_W = 17,
  parameter int STEPS = 8,
  parameter int QUO_W = 8
) (
  input  logic             clk,
  input  logic [DEN_W-1:0] num_hi,
  input  logic [STEPS-1:0] num_lo,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  logic [DEN_W-1:0] rem_r [STEPS];
  logic [STEPS-1:0] lo_r  [STEPS];
  logic [DEN_W-1:0] den_r [STEPS];
  logic [QUO_W-1:0] q_r   [STEPS];

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [STEPS-1:0] lo_in;
    logic [QUO_W-1:0] q_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [QUO_W:0]   q_sh;
    logic [DEN_W-1:0] rem_nxt;

    if (s == 0) begin : g_first
      assign rem_in = num_hi;
      assign lo_in  = num_lo;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign lo_in  = lo_r[s-1];
      assign den_in = den_r[s-1];
      assign q_in   = q_r[s-1];
    end

    // bring down one dividend bit, subtract when it fits
    assign trial   = {rem_in, lo_in[STEPS-1]};
    assign ge      = trial >= {1'b0, den_in};
    assign diff    = trial - {1'b0, den_in};
    assign rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    assign q_sh    = {q_in, ge};

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_nxt;
      lo_r[s]  <= lo_in << 1;
      den_r[s] <= den_in;
      q_r[s]   <= q_sh[QUO_W-1:0];
    end
  end

  assign quo = q_r[STEPS-1];

endmodule

// ===== src/textured_wall_pixel_shader.sv =====
// Textured wall pixel shader: texture store, texel row divider and per-channel distance shading.
// Depends on twps_pkg and twps_div.
//
//  channel  | ports                                      | handshake
//  ---------+--------------------------------------------+-------------------------------
//  input    | in_kind .. in_face_side                    | taken when start && !busy
//  result   | out_pixel_x, out_pixel_y, out_pixel_color  | out_valid high for one cycle
//
// One item enters every clock; busy never rises and the receiver cannot stall, so nothing waits.
// A shade item's pixel passes through the stage 1 and stage 2 registers, the one-bit-per-stage
// texel row divider, the memory read and product registers and the 8-stage shading dividers
// before it is strobed. Load items and shade items access the texture memory at the same stage,
// so they act in arrival order.
// rst_n clears the valid bits and the loaded flags; texture contents stay as they were.
module textured_wall_pixel_shader #(
  parameter int TEX_SIDE      = 64,
  parameter int SCREEN_HEIGHT = 480,
  parameter int TEX_COUNT     = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [2:0]  in_tex_index,
  input  logic [5:0]  in_tex_column,
  input  logic [5:0]  in_tex_row,
  input  logic [23:0] in_texel_color,
  input  logic [9:0]  in_screen_column,
  input  logic [8:0]  in_row,
  input  logic [15:0] in_slice_height,
  input  logic [15:0] in_distance,
  input  logic        in_face_side,
  output logic        out_valid,
  output logic [9:0]  out_pixel_x,
  output logic [8:0]  out_pixel_y,
  output logic [23:0] out_pixel_color
);

  localparam int TB          = $clog2(TEX_SIDE);
  localparam int ROW_STEPS   = twps_pkg::NMAG_W + TB;
  localparam int DEPTH       = TEX_COUNT * TEX_SIDE * TEX_SIDE;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int SHADE_STEPS = twps_pkg::CHAN_W;
  localparam logic [twps_pkg::NMAG_W-1:0] HALF_H = twps_pkg::NMAG_W'(SCREEN_HEIGHT / 2);

  typedef struct packed {
    twps_pkg::item_kind_t                kind;
    logic                                ok;
    logic [2:0]                          tex;
    logic [5:0]                          tcol;
    logic [5:0]                          trow;
    logic [twps_pkg::COLOR_W-1:0]        color;
    logic [9:0]                          sx;
    logic [8:0]                          sy;
    logic                                neg;
    logic [twps_pkg::SHADE_NUM_W-1:0]    snum;
    logic [twps_pkg::SHADE_DEN_W-1:0]    sden;
  } side_t;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // ---------------- stage 1: half-height sum, item checks, shading ratio
  logic                          tex_in_range;
  logic                          col_in_range;
  logic                          row_in_range;
  logic [twps_pkg::CLAMP_W-1:0]  dist3;
  logic                          clamp;
  side_t                         sb1_nxt;

  assign tex_in_range = int'(in_tex_index) < TEX_COUNT;
  assign col_in_range = int'(in_tex_column) < TEX_SIDE;
  assign row_in_range = int'(in_tex_row) < TEX_SIDE;
  assign dist3 = {2'b00, in_distance} + {1'b0, in_distance, 1'b0};
  assign clamp = dist3 > twps_pkg::CLAMP_LIMIT;

  always_comb begin
    sb1_nxt       = '0;
    sb1_nxt.kind  = twps_pkg::item_kind_t'(in_kind);
    sb1_nxt.ok    = tex_in_range && col_in_range &&
                    ((in_kind == twps_pkg::KIND_SHADE) ? (in_slice_height != '0) : row_in_range);
    sb1_nxt.tex   = in_tex_index;
    sb1_nxt.tcol  = in_tex_column;
    sb1_nxt.trow  = in_tex_row;
    sb1_nxt.color = in_texel_color;
    sb1_nxt.sx    = in_screen_column;
    sb1_nxt.sy    = in_row;
    case ({clamp, in_face_side})
      2'b00: begin
        sb1_nxt.snum = twps_pkg::SHADE_BASE_NUM;
        sb1_nxt.sden = twps_pkg::SHADE_BASE_DEN + twps_pkg::SHADE_DEN_W'(in_distance);
      end
      2'b01: begin
        sb1_nxt.snum = twps_pkg::SHADE_DARK_NUM;
        sb1_nxt.sden = twps_pkg::SHADE_BASE_DEN + twps_pkg::SHADE_DEN_W'(in_distance);
      end
      2'b10: begin
        sb1_nxt.snum = twps_pkg::CLAMP_NUM;
        sb1_nxt.sden = twps_pkg::CLAMP_DEN;
      end
      default: begin
        sb1_nxt.snum = twps_pkg::CLAMP_DARK_NUM;
        sb1_nxt.sden = twps_pkg::CLAMP_DARK_DEN;
      end
    endcase
  end

  logic                          v1_r;
  side_t                         sb1_r;
  logic [twps_pkg::NMAG_W-1:0]   sum1_r;
  logic [twps_pkg::LH_W-1:0]     lh1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    sb1_r  <= sb1_nxt;
    sum1_r <= twps_pkg::NMAG_W'(in_row) + twps_pkg::NMAG_W'(in_slice_height >> 1);
    lh1_r  <= in_slice_height;
  end

  // ---------------- stage 2: sign and magnitude of the centered row
  logic                          v2_r;
  side_t                         sb2_r;
  side_t                         sb2_nxt;
  logic [twps_pkg::NMAG_W-1:0]   mag2_r;
  logic [twps_pkg::LH_W-1:0]     lh2_r;
  logic                          neg1;

  assign neg1 = sum1_r < HALF_H;

  always_comb begin
    sb2_nxt     = sb1_r;
    sb2_nxt.neg = neg1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    sb2_r     <= sb2_nxt;
    mag2_r    <= neg1 ? (HALF_H - sum1_r) : (sum1_r - HALF_H);
    lh2_r     <= lh1_r;
  end

  // ---------------- texel row divider: |n| * TEX_SIDE / slice height, low bits kept
  logic [TB-1:0] row_q;

  twps_div #(
    .DEN_W (twps_pkg::LH_W),
    .STEPS (ROW_STEPS),
    .QUO_W (TB)
  ) u_row_div (
    .clk    (clk),
    .num_hi ('0),
    .num_lo ({mag2_r, {TB{1'b0}}}),
    .den    (lh2_r),
    .quo    (row_q)
  );

  logic [ROW_STEPS-1:0] vd_r;
  side_t                sbd_r [ROW_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= '0;
    end else begin
      vd_r <= {vd_r[ROW_STEPS-2:0], v2_r};
    end
  end

  always_ff @(posedge clk) begin
    sbd_r[0] <= sb2_r;
    for (int i = 1; i < ROW_STEPS; i++) begin
      sbd_r[i] <= sbd_r[i-1];
    end
  end

  // ---------------- memory stage: loads write, shades read, in arrival order
  side_t                  sbm;
  logic                   vm;
  logic [TB-1:0]          tex_row_sel;
  logic [2+2*TB:0]        addr_full;
  logic [ADDR_W-1:0]      mem_addr;
  logic [TEX_COUNT-1:0]   tex_mask;
  logic                   loaded_hit;
  logic                   mem_we;
  logic [TEX_COUNT-1:0]   loaded_r;

  assign sbm = sbd_r[ROW_STEPS-1];
  assign vm  = vd_r[ROW_STEPS-1];

  // negative rows wrap: two's complement of the truncated quotient
  assign tex_row_sel = (sbm.kind == twps_pkg::KIND_SHADE) ?
                       (sbm.neg ? (TB'(0) - row_q) : row_q) : TB'(sbm.trow);
  assign addr_full   = {sbm.tex, tex_row_sel, TB'(sbm.tcol)};
  assign mem_addr    = addr_full[ADDR_W-1:0];
  assign tex_mask    = TEX_COUNT'(1) << sbm.tex;
  assign loaded_hit  = |(loaded_r & tex_mask);
  assign mem_we      = vm && sbm.ok && (sbm.kind == twps_pkg::KIND_LOAD);

  logic [twps_pkg::COLOR_W-1:0] tex_mem [DEPTH];
  logic [twps_pkg::COLOR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tex_mem[mem_addr] <= sbm.color;
    end
    rd_data_r <= tex_mem[mem_addr];
  end

  logic                                rd_v_r;
  logic [9:0]                          rd_sx_r;
  logic [8:0]                          rd_sy_r;
  logic [twps_pkg::SHADE_NUM_W-1:0]    rd_num_r;
  logic [twps_pkg::SHADE_DEN_W-1:0]    rd_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r   <= 1'b0;
      loaded_r <= '0;
    end else begin
      rd_v_r <= vm && sbm.ok && (sbm.kind == twps_pkg::KIND_SHADE) && loaded_hit;
      if (mem_we) begin
        loaded_r <= loaded_r | tex_mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_sx_r  <= sbm.sx;
    rd_sy_r  <= sbm.sy;
    rd_num_r <= sbm.snum;
    rd_den_r <= sbm.sden;
  end

  // ---------------- product stage: channel times shading numerator
  logic                                prod_v_r;
  logic [twps_pkg::PROD_W-1:0]         prod_r [3];
  logic [twps_pkg::SHADE_DEN_W-1:0]    prod_den_r;
  logic [9:0]                          prod_sx_r;
  logic [8:0]                          prod_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      prod_r[c] <= twps_pkg::PROD_W'(rd_data_r[c*twps_pkg::CHAN_W +: twps_pkg::CHAN_W]) *
                   twps_pkg::PROD_W'(rd_num_r);
    end
    prod_den_r <= rd_den_r;
    prod_sx_r  <= rd_sx_r;
    prod_sy_r  <= rd_sy_r;
  end

  // ---------------- shading dividers, quotient never exceeds one channel
  logic [twps_pkg::COLOR_W-1:0] shaded;

  for (genvar c = 0; c < 3; c++) begin : g_chan
    twps_div #(
      .DEN_W (twps_pkg::SHADE_DEN_W),
      .STEPS (SHADE_STEPS),
      .QUO_W (twps_pkg::CHAN_W)
    ) u_shade_div (
      .clk    (clk),
      .num_hi (twps_pkg::SHADE_DEN_W'(prod_r[c][twps_pkg::PROD_W-1:SHADE_STEPS])),
      .num_lo (prod_r[c][SHADE_STEPS-1:0]),
      .den    (prod_den_r),
      .quo    (shaded[c*twps_pkg::CHAN_W +: twps_pkg::CHAN_W])
    );
  end

  logic [SHADE_STEPS-1:0] pv_r;
  logic [9:0]             px_r [SHADE_STEPS];
  logic [8:0]             py_r [SHADE_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else begin
      pv_r <= {pv_r[SHADE_STEPS-2:0], prod_v_r};
    end
  end

  always_ff @(posedge clk) begin
    px_r[0] <= prod_sx_r;
    py_r[0] <= prod_sy_r;
    for (int i = 1; i < SHADE_STEPS; i++) begin
      px_r[i] <= px_r[i-1];
      py_r[i] <= py_r[i-1];
    end
  end

  assign out_valid       = pv_r[SHADE_STEPS-1];
  assign out_pixel_x     = px_r[SHADE_STEPS-1];
  assign out_pixel_y     = py_r[SHADE_STEPS-1];
  assign out_pixel_color = shaded;

`ifndef SYNTHESIS
  // loaded flags only ever get set
  a_loaded_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (loaded_r & $past(loaded_r)) == $past(loaded_r))
    else $error("texture loaded flag dropped");

  // no pixel leaves the memory stage while no texture is loaded
  a_no_tex_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (loaded_r == '0) |=> !rd_v_r)
    else $error("pixel read from an unloaded texture");

  // result strobe lines up with the product stage through the shading dividers
  a_shade_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(prod_v_r, SHADE_STEPS))
    else $error("result strobe out of step with shading pipeline");
`endif

endmodule
